/* rtl/hnt_pkg.sv */
// Shared types and constants of the height map normal and tangent generator.
`default_nettype none
package hnt_pkg;

  localparam int LINE_DEPTH = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int COL_W      = $clog2(LINE_DEPTH);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int DIM_W      = 11;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_X_STEP       = 2'd2;
  localparam logic [1:0] CFG_Y_STEP       = 2'd3;

  typedef struct packed {
    logic [15:0] height_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic [14:0]        normal_y;
    logic signed [15:0] normal_z;
    logic [14:0]        tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] bitangent_y;
    logic [14:0]        bitangent_z;
    logic [15:0]        height_out;
    logic [COL_W-1:0]   out_col;
    logic [ROW_W-1:0]   out_row;
    logic               last_of_frame;
  } out_item_t;

  // One pixel to be finished: its two central differences and its tags.
  typedef struct packed {
    logic signed [16:0] diff_x;
    logic signed [16:0] diff_y;
    logic [15:0]        height;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               last;
  } job_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } geom_t;

  typedef struct packed {
    logic [15:0] x_step;
    logic [15:0] y_step;
  } steps_t;

endpackage
`default_nettype wire

/* rtl/hnt_if.sv */
// Valid/ready stream interfaces for the input samples and the result items.
`default_nettype none
interface hnt_in_if;
  logic               valid;
  logic               ready;
  hnt_pkg::in_item_t  payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface hnt_out_if;
  logic               valid;
  logic               ready;
  hnt_pkg::out_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/hnt_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module hnt_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);
  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/hnt_fifo.sv */
// Short job queue between the line store front end and the normalising back end.
`default_nettype none
module hnt_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire hnt_pkg::job_t data_i,
  input  wire logic          pop_i,
  output hnt_pkg::job_t      data_o,
  output logic               full_o,
  output logic               empty_o
);
  hnt_pkg::job_t                 mem_q [hnt_pkg::FIFO_DEPTH];
  logic [hnt_pkg::FIFO_AW-1:0]   wptr_q, rptr_q;
  logic [hnt_pkg::FIFO_AW:0]     count_q;

  assign full_o  = (count_q == (hnt_pkg::FIFO_AW+1)'(hnt_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/hnt_front.sv */
// Front end: takes samples, keeps the two line stores and queues up to three pixel jobs.
`default_nettype none
module hnt_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  hnt_in_if.sink              in_if,
  input  wire hnt_pkg::geom_t geom_i,
  output hnt_pkg::job_t       job_o,
  output logic                push_o,
  input  wire logic           full_i
);
  localparam int CW = hnt_pkg::COL_W;
  localparam int RW = hnt_pkg::ROW_W;
  localparam int DW = hnt_pkg::DIM_W;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RD1  = 2'd1;
  localparam logic [1:0] F_RD2  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] col_q, col_d, c_q, c_d;
  logic [RW-1:0] row_q, row_d, r_q, r_d;
  logic [1:0]    k_q, k_d;
  logic [15:0]   s_q, old_up_q, old_mid_q, nxt_q, prev_mid_q, cur1_q, cur2_q;

  logic          accept;
  logic [DW-1:0] col_ext, row_tmp;
  logic          col_wrap;
  logic [CW-1:0] c_acc;
  logic [RW-1:0] r_acc;
  logic [CW-1:0] up_raddr, mid_raddr;
  logic [15:0]   up_rdata, mid_rdata;
  logic          ram_we;
  logic [DW-1:0] c1, r1;
  logic          last_row, first_col, second_col, last_col, has_right;
  logic [15:0]   j_left, j_right, j_top, j_bot;
  logic          j_valid;

  assign in_if.ready = (state_q == F_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  // A column count beyond the width starts a new row; a row beyond the height a new frame.
  always_comb begin
    col_ext  = {1'b0, col_q};
    col_wrap = (col_ext >= geom_i.width);
    c_acc    = col_wrap ? '0 : col_q;
    row_tmp  = col_wrap ? ({1'b0, row_q} + 1'b1) : {1'b0, row_q};
    r_acc    = (row_tmp >= geom_i.height) ? '0 : row_tmp[RW-1:0];
  end

  assign up_raddr  = (state_q == F_IDLE) ? c_acc : c_q;
  assign mid_raddr = (state_q == F_IDLE) ? c_acc : (c_q + 1'b1);
  assign ram_we    = (state_q == F_RD1);

  hnt_ram #(.DATA_W(16), .DEPTH(hnt_pkg::LINE_DEPTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i (mid_rdata),
    .raddr_i (up_raddr),
    .rdata_o (up_rdata)
  );

  hnt_ram #(.DATA_W(16), .DEPTH(hnt_pkg::LINE_DEPTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i (s_q),
    .raddr_i (mid_raddr),
    .rdata_o (mid_rdata)
  );

  always_comb begin
    c1         = {1'b0, c_q} + 1'b1;
    r1         = {1'b0, r_q} + 1'b1;
    last_row   = (r1 == geom_i.height);
    first_col  = (c_q == '0);
    second_col = (c_q == CW'(1));
    last_col   = (c1 == geom_i.width);
    has_right  = !last_col;
    j_valid    = 1'b0;
    j_left     = '0;
    j_right    = '0;
    j_top      = '0;
    j_bot      = '0;
    job_o      = '0;
    case (k_q)
      2'd0: begin
        // Pixel one row up in this column, neighbours mirrored at the row edges.
        j_valid    = (r_q != '0);
        j_left     = first_col ? nxt_q : prev_mid_q;
        j_right    = has_right ? nxt_q : prev_mid_q;
        j_top      = (r_q >= RW'(2)) ? old_up_q : s_q;
        j_bot      = s_q;
        job_o.height = old_mid_q;
        job_o.col    = c_q;
        job_o.row    = r_q - 1'b1;
        job_o.last   = 1'b0;
      end
      2'd1: begin
        // On the final row, the pixel to the left can now be finished.
        j_valid    = last_row && !first_col;
        j_left     = second_col ? s_q : cur2_q;
        j_right    = s_q;
        j_top      = prev_mid_q;
        j_bot      = prev_mid_q;
        job_o.height = cur1_q;
        job_o.col    = c_q - 1'b1;
        job_o.row    = r_q;
        job_o.last   = 1'b0;
      end
      default: begin
        // The final pixel of the frame finishes itself.
        j_valid    = last_row && last_col;
        j_left     = cur1_q;
        j_right    = cur1_q;
        j_top      = old_mid_q;
        j_bot      = old_mid_q;
        job_o.height = s_q;
        job_o.col    = c_q;
        job_o.row    = r_q;
        job_o.last   = 1'b1;
      end
    endcase
    job_o.diff_x = $signed({1'b0, j_right}) - $signed({1'b0, j_left});
    job_o.diff_y = $signed({1'b0, j_bot}) - $signed({1'b0, j_top});
  end

  assign push_o = (state_q == F_PUSH) && j_valid && !full_i;

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    c_d     = c_q;
    r_d     = r_q;
    k_d     = k_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          c_d     = c_acc;
          r_d     = r_acc;
          state_d = F_RD1;
        end
      end
      F_RD1: state_d = F_RD2;
      F_RD2: begin
        k_d     = 2'd0;
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!j_valid || !full_i) begin
          if (k_q == 2'd2) begin
            state_d = F_IDLE;
            if (c1 >= geom_i.width) begin
              col_d = '0;
              row_d = (r1 >= geom_i.height) ? '0 : r1[RW-1:0];
            end else begin
              col_d = c1[CW-1:0];
              row_d = r_q;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    r_q <= r_d;
    if (accept) begin
      s_q <= in_if.payload.height_sample;
    end
    if (state_q == F_RD1) begin
      old_up_q  <= up_rdata;
      old_mid_q <= mid_rdata;
    end
    if (state_q == F_RD2) begin
      nxt_q <= mid_rdata;
    end
    if (state_d == F_IDLE && state_q == F_PUSH) begin
      prev_mid_q <= old_mid_q;
      cur2_q     <= cur1_q;
      cur1_q     <= s_q;
    end
  end
endmodule
`default_nettype wire

/* rtl/hnt_norm.sv */
// Iterative unit that scales a three component vector to unit length in UQ0.15.
`default_nettype none
module hnt_norm (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [2:0][31:0] mag_i,
  output logic      [2:0][14:0] unit_o,
  output logic                  done_o
);
  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SUM   = 3'd3;
  localparam logic [2:0] N_DINIT = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;
  localparam logic [2:0] N_SQRT  = 3'd6;

  logic [2:0]       state_q;
  logic             done_q;
  logic [1:0]       k_q;
  logic [2:0][31:0] mag_q;
  logic [2:0][15:0] m_q;
  logic [2:0][31:0] sq_q;
  logic [33:0]      sum_q;
  logic [33:0]      rem_q;
  logic [30:0]      quo_q;
  logic [4:0]       cnt_q;
  logic [30:0]      x_q;
  logic [31:0]      res_q;
  logic [30:0]      bit_q;
  logic [2:0][14:0] unit_q;

  logic [31:0] mx;
  logic [4:0]  sh;
  logic [33:0] sq_ext;
  logic        ge0;
  logic [34:0] rem2;
  logic        ge;
  logic [30:0] quo_n;
  logic [31:0] trial;
  logic        take;
  logic [31:0] res_n;
  logic [14:0] r_sat;

  assign unit_o = unit_q;
  assign done_o = done_q;

  always_comb begin
    mx = mag_q[0];
    if (mag_q[1] > mx) mx = mag_q[1];
    if (mag_q[2] > mx) mx = mag_q[2];
    sh = '0;
    for (int i = 0; i < 16; i++) begin
      if (mx[16+i]) sh = 5'(i + 1);
    end
    sq_ext = {2'b0, sq_q[k_q]};
    ge0    = (sq_ext >= sum_q);
    rem2   = {rem_q, 1'b0};
    ge     = (rem2 >= {1'b0, sum_q});
    quo_n  = {quo_q[29:0], ge};
    trial  = res_q + {1'b0, bit_q};
    take   = ({1'b0, x_q} >= trial);
    res_n  = take ? ((res_q >> 1) + {1'b0, bit_q}) : (res_q >> 1);
    if (sum_q == '0) begin
      r_sat = '0;
    end else if (res_n > 32'd32767) begin
      r_sat = 15'h7fff;
    end else begin
      r_sat = res_n[14:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      case (state_q)
        N_IDLE: begin
          if (start_i) begin
            done_q  <= 1'b0;
            state_q <= N_SHIFT;
          end
        end
        N_SHIFT: state_q <= N_SQ;
        N_SQ:    state_q <= N_SUM;
        N_SUM: begin
          k_q     <= '0;
          state_q <= N_DINIT;
        end
        N_DINIT: state_q <= N_DIV;
        N_DIV: begin
          if (cnt_q == '0) state_q <= N_SQRT;
        end
        N_SQRT: begin
          if (bit_q == 31'd1) begin
            if (k_q == 2'd2) begin
              done_q  <= 1'b1;
              state_q <= N_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= N_DINIT;
            end
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        if (start_i) mag_q <= mag_i;
      end
      N_SHIFT: begin
        for (int i = 0; i < 3; i++) m_q[i] <= 16'(mag_q[i] >> sh);
      end
      N_SQ: begin
        for (int i = 0; i < 3; i++) sq_q[i] <= m_q[i] * m_q[i];
      end
      N_SUM: sum_q <= {2'b0, sq_q[0]} + {2'b0, sq_q[1]} + {2'b0, sq_q[2]};
      N_DINIT: begin
        // Integer quotient bit first, then thirty fraction bits of m*m/sum.
        rem_q <= ge0 ? (sq_ext - sum_q) : sq_ext;
        quo_q <= {30'b0, ge0};
        cnt_q <= 5'd29;
      end
      N_DIV: begin
        rem_q <= ge ? 34'(rem2 - {1'b0, sum_q}) : rem2[33:0];
        quo_q <= quo_n;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          x_q   <= quo_n;
          res_q <= '0;
          bit_q <= 31'h4000_0000;
        end
      end
      N_SQRT: begin
        if (take) x_q <= 31'({1'b0, x_q} - trial);
        res_q <= res_n;
        bit_q <= bit_q >> 2;
        if (bit_q == 31'd1) unit_q[k_q] <= r_sat;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/hnt_back.sv */
// Back end: builds the three frame vectors of a job, normalises them and holds the result.
`default_nettype none
module hnt_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire hnt_pkg::steps_t steps_i,
  input  wire hnt_pkg::job_t   job_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  hnt_out_if.source            out_if
);
  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_MUL   = 2'd1;
  localparam logic [1:0] B_START = 2'd2;
  localparam logic [1:0] B_WAIT  = 2'd3;

  logic [1:0]         state_q;
  hnt_pkg::job_t      job_q;
  logic [2:0][31:0]   tan_mag_q, bit_mag_q, nrm_mag_q;
  logic [2:0][14:0]   tan_unit, bit_unit, nrm_unit;
  logic               tan_done, bit_done, nrm_done;
  logic               start;
  logic [16:0]        dabs17, eabs17;
  logic [15:0]        dabs, eabs;
  logic               load;
  hnt_pkg::out_item_t out_q, out_d;
  logic               out_valid_q;

  function automatic logic signed [15:0] apply_sign(logic [14:0] mag, logic neg);
    logic signed [15:0] ext;
    ext = $signed({1'b0, mag});
    return neg ? -ext : ext;
  endfunction

  assign pop_o  = (state_q == B_IDLE) && !empty_i;
  assign start  = (state_q == B_START);
  assign dabs17 = job_q.diff_x[16] ? 17'(-job_q.diff_x) : job_q.diff_x;
  assign eabs17 = job_q.diff_y[16] ? 17'(-job_q.diff_y) : job_q.diff_y;
  assign dabs   = dabs17[15:0];
  assign eabs   = eabs17[15:0];
  assign load   = (state_q == B_WAIT) && tan_done && bit_done && nrm_done
                  && (!out_valid_q || out_if.ready);

  hnt_norm u_tan (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start),
    .mag_i (tan_mag_q), .unit_o (tan_unit), .done_o (tan_done)
  );
  hnt_norm u_bit (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start),
    .mag_i (bit_mag_q), .unit_o (bit_unit), .done_o (bit_done)
  );
  hnt_norm u_nrm (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start),
    .mag_i (nrm_mag_q), .unit_o (nrm_unit), .done_o (nrm_done)
  );

  always_comb begin
    out_d               = '0;
    // The normal points against the slopes: its x and z signs are opposite to d and e.
    out_d.normal_x      = apply_sign(nrm_unit[0],
                                     !job_q.diff_x[16] && (job_q.diff_x != '0));
    out_d.normal_y      = nrm_unit[1];
    out_d.normal_z      = apply_sign(nrm_unit[2],
                                     !job_q.diff_y[16] && (job_q.diff_y != '0));
    out_d.tangent_x     = tan_unit[0];
    out_d.tangent_y     = apply_sign(tan_unit[1], job_q.diff_x[16]);
    out_d.bitangent_y   = apply_sign(bit_unit[1], job_q.diff_y[16]);
    out_d.bitangent_z   = bit_unit[2];
    out_d.height_out    = job_q.height;
    out_d.out_col       = job_q.col;
    out_d.out_row       = job_q.row;
    out_d.last_of_frame = job_q.last;
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        B_IDLE:  if (!empty_i) state_q <= B_MUL;
        B_MUL:   state_q <= B_START;
        B_START: state_q <= B_WAIT;
        B_WAIT:  if (load) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == B_MUL) begin
      tan_mag_q[0] <= {16'b0, steps_i.x_step};
      tan_mag_q[1] <= {16'b0, dabs};
      tan_mag_q[2] <= '0;
      bit_mag_q[0] <= '0;
      bit_mag_q[1] <= {16'b0, eabs};
      bit_mag_q[2] <= {16'b0, steps_i.y_step};
      nrm_mag_q[0] <= steps_i.y_step * dabs;
      nrm_mag_q[1] <= steps_i.x_step * steps_i.y_step;
      nrm_mag_q[2] <= eabs * steps_i.x_step;
    end
    if (load) begin
      out_q <= out_d;
    end
  end
endmodule
`default_nettype wire

/* rtl/heightmap_normal_tangent_gen.sv */
// Top level of the height map normal, tangent and bitangent generator.
//
// Height samples enter on in_if in raster order, one transfer per pixel, for a map
// of image_width by image_height pixels set through the write port (cfg_we_i,
// cfg_idx_i, cfg_data_i) while the block is idle. Each result transfer on out_if
// carries the unit normal, tangent and bitangent of one pixel in Q1.15 with its
// height, column, row and a flag on the final pixel of the frame.
// A result for row y leaves once the sample of the same column in row y+1 has
// arrived; the final row is finished by its own samples, so one input releases
// between zero and three results.
// The front end takes a new sample only when idle, once it has pushed the jobs
// of the last one. The back end takes one job at a time: three iterative
// normalisers run in parallel, each dividing and taking a square root bit by
// bit for three components in turn, which sets the throughput of the block.
// Results wait in an output register; while out_if is stalled the back end holds,
// the four-entry job queue fills and the front end then stops taking samples.
// Reset clears the counters, the queue and all handshakes and restores the
// register defaults (1024 by 1024, steps of 128). The line stores are not cleared.
`default_nettype none
module heightmap_normal_tangent_gen (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  hnt_in_if.sink           in_if,
  hnt_out_if.source        out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int DW = hnt_pkg::DIM_W;

  logic [DW-1:0] width_q, height_q;
  logic [15:0]   x_step_q, y_step_q;

  hnt_pkg::geom_t  geom;
  hnt_pkg::steps_t steps;
  hnt_pkg::job_t   push_job, pop_job;
  logic            push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DW'(hnt_pkg::LINE_DEPTH);
      height_q <= DW'(hnt_pkg::MAX_ROWS);
      x_step_q <= 16'd128;
      y_step_q <= 16'd128;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hnt_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[DW-1:0];
        hnt_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[DW-1:0];
        hnt_pkg::CFG_X_STEP:       x_step_q <= cfg_data_i;
        hnt_pkg::CFG_Y_STEP:       y_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sizes are clamped to the range the line stores hold; a zero step counts as one.
  always_comb begin
    if (width_q < DW'(2)) begin
      geom.width = DW'(2);
    end else if (width_q > DW'(hnt_pkg::LINE_DEPTH)) begin
      geom.width = DW'(hnt_pkg::LINE_DEPTH);
    end else begin
      geom.width = width_q;
    end
    if (height_q < DW'(2)) begin
      geom.height = DW'(2);
    end else if (height_q > DW'(hnt_pkg::MAX_ROWS)) begin
      geom.height = DW'(hnt_pkg::MAX_ROWS);
    end else begin
      geom.height = height_q;
    end
    steps.x_step = (x_step_q == '0) ? 16'd1 : x_step_q;
    steps.y_step = (y_step_q == '0) ? 16'd1 : y_step_q;
  end

  hnt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .geom_i (geom),
    .job_o  (push_job),
    .push_o (push),
    .full_i (full)
  );

  hnt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (pop_job),
    .full_o  (full),
    .empty_o (empty)
  );

  hnt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .steps_i (steps),
    .job_i   (pop_job),
    .empty_i (empty),
    .pop_o   (pop),
    .out_if  (out_if)
  );
endmodule
`default_nettype wire

/* tb/tb_heightmap_normal_tangent_gen.sv */
// Self-checking testbench of the height map normal, tangent and bitangent generator.
`timescale 1ns / 100ps

module tb_heightmap_normal_tangent_gen;

  // Predicts the surface frame of every pixel from the accepted height samples and
  // checks the result transfers against the predictions in order.
  class surface_frame_predictor;
    logic [hnt_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [15:0]               x_step_reg, y_step_reg;
    logic [15:0]               upper_row [hnt_pkg::LINE_DEPTH];
    logic [15:0]               middle_row[hnt_pkg::LINE_DEPTH];
    int unsigned               col_pos, row_pos;
    hnt_pkg::out_item_t        frames_due[$];
    int                        mismatches;
    int                        frames_checked;

    function new();
      width_reg  = 11'd1024;
      height_reg = 11'd1024;
      x_step_reg = 16'd128;
      y_step_reg = 16'd128;
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      col_pos = 0;
      row_pos = 0;
      mismatches = 0;
      frames_checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        hnt_pkg::CFG_IMAGE_WIDTH:  width_reg  = val[hnt_pkg::DIM_W-1:0];
        hnt_pkg::CFG_IMAGE_HEIGHT: height_reg = val[hnt_pkg::DIM_W-1:0];
        hnt_pkg::CFG_X_STEP:       x_step_reg = val;
        default:                   y_step_reg = val;
      endcase
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // Bitwise integer square root, floor.
    function longint unsigned isqrt(longint unsigned x);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x   = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Scales a vector to unit length in Q1.15, saturating +1.0 to 32767.
    function void normalise(input longint v[3], output int q[3]);
      longint unsigned mag[3];
      longint unsigned biggest, sum, r;
      biggest = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
        if (mag[i] > biggest) biggest = mag[i];
      end
      while (biggest >= 65536) begin
        biggest = biggest >> 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      for (int i = 0; i < 3; i++) begin
        r = 0;
        if (sum != 0) r = isqrt(((mag[i] * mag[i]) << 30) / sum);
        if (r > 32767) r = 32767;
        q[i] = (v[i] < 0) ? -int'(r) : int'(r);
      end
    endfunction

    function void predict_frame(logic [15:0] ctr, logic [15:0] lf, logic [15:0] rt,
                                logic [15:0] tp, logic [15:0] bt, int unsigned c,
                                int unsigned r, bit last);
      longint xs, ys, d, e;
      longint tv[3], bv[3], nv[3];
      int tq[3], bq[3], nq[3];
      hnt_pkg::out_item_t f;
      xs = (x_step_reg == 0) ? 1 : x_step_reg;
      ys = (y_step_reg == 0) ? 1 : y_step_reg;
      d  = longint'(rt) - longint'(lf);
      e  = longint'(bt) - longint'(tp);
      tv = '{xs, d, 0};
      bv = '{0, e, ys};
      nv = '{-(ys * d), xs * ys, -(e * xs)};
      normalise(tv, tq);
      normalise(bv, bq);
      normalise(nv, nq);
      f.normal_x      = 16'(nq[0]);
      f.normal_y      = 15'(nq[1]);
      f.normal_z      = 16'(nq[2]);
      f.tangent_x     = 15'(tq[0]);
      f.tangent_y     = 16'(tq[1]);
      f.bitangent_y   = 16'(bq[1]);
      f.bitangent_z   = 15'(bq[2]);
      f.height_out    = ctr;
      f.out_col       = hnt_pkg::COL_W'(c);
      f.out_row       = hnt_pkg::ROW_W'(r);
      f.last_of_frame = last;
      frames_due.push_back(f);
    endfunction

    // Called for every accepted height sample.
    function void note_sample(logic [15:0] s);
      int unsigned w, h, c, r;
      logic [15:0] old_up, old_mid, top, lf, rt, ctr, tp;
      w = (width_reg < 2) ? 2 : width_reg;
      h = (height_reg < 2) ? 2 : height_reg;
      if (w > hnt_pkg::LINE_DEPTH) w = hnt_pkg::LINE_DEPTH;
      if (h > hnt_pkg::MAX_ROWS) h = hnt_pkg::MAX_ROWS;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      old_up  = upper_row[c];
      old_mid = middle_row[c];
      upper_row[c]  = old_mid;
      middle_row[c] = s;
      if (r >= 1) begin
        top = (r >= 2) ? old_up : s;
        lf  = (c >= 1) ? upper_row[c-1] : middle_row[c+1];
        rt  = (c + 1 < w) ? middle_row[c+1] : upper_row[c-1];
        predict_frame(old_mid, lf, rt, top, s, c, r - 1, 1'b0);
        if (r == h - 1) begin
          if (c >= 1) begin
            ctr = middle_row[c-1];
            lf  = (c >= 2) ? middle_row[c-2] : s;
            tp  = upper_row[c-1];
            predict_frame(ctr, lf, s, tp, tp, c - 1, r, 1'b0);
          end
          if (c == w - 1) begin
            lf = middle_row[c-1];
            tp = upper_row[c];
            predict_frame(s, lf, lf, tp, tp, c, r, 1'b1);
          end
        end
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    // Called for every accepted result transfer.
    function void check_frame(hnt_pkg::out_item_t got);
      hnt_pkg::out_item_t exp_f;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      exp_f = frames_due.pop_front();
      frames_checked++;
      cmp("normal_x", exp_f.normal_x, got.normal_x);
      cmp("normal_y", exp_f.normal_y, got.normal_y);
      cmp("normal_z", exp_f.normal_z, got.normal_z);
      cmp("tangent_x", exp_f.tangent_x, got.tangent_x);
      cmp("tangent_y", exp_f.tangent_y, got.tangent_y);
      cmp("bitangent_y", exp_f.bitangent_y, got.bitangent_y);
      cmp("bitangent_z", exp_f.bitangent_z, got.bitangent_z);
      cmp("height_out", exp_f.height_out, got.height_out);
      cmp("out_col", exp_f.out_col, got.out_col);
      cmp("out_row", exp_f.out_row, got.out_row);
      cmp("last_of_frame", exp_f.last_of_frame, got.last_of_frame);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  hnt_in_if  in_bus();
  hnt_out_if out_bus();

  heightmap_normal_tangent_gen uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  surface_frame_predictor frames = new();

  // While steady is set neither side idles; this gives short stretches at full rate.
  bit steady;
  int samples_sent;
  int maps_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The sink stalls at random, 38 percent of the time, outside the steady stretches.
  always @(negedge clk_i) begin
    out_bus.ready <= steady || ($urandom_range(99) >= 38);
  end

  // Every result transfer is checked at the rising edge on which it happens.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      frames.check_frame(out_bus.payload);
    end
  end

  // Writes one register; the block is idle whenever this is called.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    frames.write_reg(idx, val);
  endtask

  task automatic set_geometry(int w, int h, int xs, int ys);
    write_reg(hnt_pkg::CFG_IMAGE_WIDTH, 16'(w));
    write_reg(hnt_pkg::CFG_IMAGE_HEIGHT, 16'(h));
    write_reg(hnt_pkg::CFG_X_STEP, 16'(xs));
    write_reg(hnt_pkg::CFG_Y_STEP, 16'(ys));
  endtask

  // Offers one sample, at random with a gap in front of it, and returns once the
  // transfer has happened. valid stays high between back-to-back samples.
  task automatic send_sample(logic [15:0] s);
    if (!steady && $urandom_range(99) < 38) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid   <= 1'b1;
    in_bus.payload <= s;
    do @(posedge clk_i); while (!in_bus.ready);
    frames.note_sample(s);
    samples_sent++;
  endtask

  // Waits until every predicted result has arrived, then lets the back end settle.
  task automatic drain();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (frames.pending() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // Sends one whole map. Styles: 0 full-range noise, 1 smooth ramp with small
  // noise, 2 only the extremes 0 and 65535.
  task automatic send_map(int w, int h, int style);
    int base, slope_x, slope_y;
    logic [15:0] s;
    base    = $urandom_range(65535);
    slope_x = $urandom_range(4000) - 2000;
    slope_y = $urandom_range(4000) - 2000;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        case (style)
          0:       s = 16'($urandom);
          1:       s = 16'(base + c * slope_x + r * slope_y + $urandom_range(63));
          default: s = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
        if (r == 4) steady = 1'b0;
        send_sample(s);
      end
    end
    maps_sent++;
  endtask

  initial begin
    int w, h, xs, ys;
    steady       = 1'b0;
    samples_sent = 0;
    maps_sent    = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = hnt_pkg::CFG_IMAGE_WIDTH;
    cfg_data_i   = '0;
    in_bus.valid   = 1'b0;
    in_bus.payload = '0;
    out_bus.ready  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Sizes below two act as two; a zero step acts as one. In the 2 by 2 map of
    // extremes both neighbours mirror onto one sample, so all differences are zero.
    set_geometry(1, 0, 0, 65535);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    drain();
    maps_sent++;

    // A 3 by 3 chequerboard with the largest x step and a zero y step.
    set_geometry(3, 3, 65535, 0);
    for (int i = 0; i < 9; i++) send_sample((i % 2) ? 16'h0000 : 16'hFFFF);
    drain();
    maps_sent++;

    // Smallest steps: a flat first row, then steep ramps.
    set_geometry(4, 3, 1, 1);
    for (int i = 0; i < 12; i++) send_sample((i < 4) ? 16'h8000 : 16'(i * 6000));
    drain();
    maps_sent++;

    // Random maps of small sizes until about 230 samples have gone in.
    while (samples_sent < 230) begin
      w  = $urandom_range(9, 2);
      h  = $urandom_range(6, 2);
      xs = ($urandom_range(3) == 0) ? $urandom_range(65535, 1) : 131072 / w;
      ys = ($urandom_range(3) == 0) ? $urandom_range(65535, 1) : 131072 / h;
      if (xs > 65535) xs = 65535;
      if (ys > 65535) ys = 65535;
      set_geometry(w, h, xs, ys);
      if (samples_sent > 120 && samples_sent < 200) steady = 1'b1;
      send_map(w, h, ($urandom_range(9) < 5) ? 1 : $urandom_range(2) ? 0 : 2);
      steady = 1'b0;
      drain();
    end

    // One wider map whose height below two is used as two.
    set_geometry(40, 1, 128, 65535);
    send_map(40, 2, 1);
    drain();

    $display("Covered %0d maps and %0d height samples, %0d surface frames checked.",
             maps_sent, samples_sent, frames.frames_checked);
    $display("Sizes ran from clamped 2 by 2 up to 40 by 2, steps from 1 to 65535.");
    if (frames.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hang: the slowest correct run stays far below this.
  initial begin
    #50000000;
    $display("Timeout with %0d results still outstanding.", frames.pending());
    $display("FAIL");
    $finish;
  end

endmodule

/* heightmap_normal_tangent_gen.f */
rtl/hnt_pkg.sv
rtl/hnt_if.sv
rtl/hnt_ram.sv
rtl/hnt_fifo.sv
rtl/hnt_front.sv
rtl/hnt_norm.sv
rtl/hnt_back.sv
rtl/heightmap_normal_tangent_gen.sv
tb/tb_heightmap_normal_tangent_gen.sv
